[sv/sync_framed_channel_refresher_core_defines.svh]
// assertion macros shared by the refresher checker
// no dependencies; included by the checker file
`ifndef SYNC_FRAMED_CHANNEL_REFRESHER_CORE_DEFINES_SVH
`define SYNC_FRAMED_CHANNEL_REFRESHER_CORE_DEFINES_SVH

// same-cycle implication
`define SFCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfcr assertion failed");

// next-cycle implication
`define SFCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfcr assertion failed");

`endif

[sv/sfcr_pkg.sv]
// shared types and codes for the channel refresher
// no dependencies
`timescale 1ns / 1ps

package sfcr_pkg;

   localparam int ChanW   = 9;
   localparam int ByteW   = 8;
   localparam int FuncW   = 2;
   localparam int CsrIdxW = 2;
   localparam int PhaseW  = 2;
   localparam int KindW   = 3;

   localparam logic [FuncW-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FuncW-1:0] FUNC_READ  = 2'd1;
   localparam logic [FuncW-1:0] FUNC_TICK  = 2'd2;

   localparam logic [CsrIdxW-1:0] CSR_FIRST_SYNC  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_SECOND_SYNC = 2'd1;

   localparam logic [PhaseW-1:0] PHASE_SYNC1 = 2'd0;
   localparam logic [PhaseW-1:0] PHASE_SYNC2 = 2'd1;
   localparam logic [PhaseW-1:0] PHASE_DATA  = 2'd2;

   // what the pending result carries
   localparam logic [KindW-1:0] KIND_NONE  = 3'd0;
   localparam logic [KindW-1:0] KIND_READ  = 3'd1;
   localparam logic [KindW-1:0] KIND_SYNC1 = 3'd2;
   localparam logic [KindW-1:0] KIND_SYNC2 = 3'd3;
   localparam logic [KindW-1:0] KIND_DATA  = 3'd4;

   typedef struct packed {
      logic clear_we;
      logic accept;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_blocked;
   } status_type;

endpackage

[sv/sfcr_ram.sv]
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sfcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                          wdata,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/sfcr_ctrl.sv]
// control state machine: clearing pass, accept, result load
// depends on sfcr_pkg
`timescale 1ns / 1ps

module sfcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sfcr_pkg::status_type status,
   output sfcr_pkg::cmd_type    cmd
);

   import sfcr_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOAD  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.clear_we = 1'b0;
      cmd.accept   = 1'b0;
      cmd.load     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // wait while an earlier result is still held
            if (!status.out_blocked) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/sfcr_dp.sv]
// datapath: level store, frame sequencing, sync registers, result register
// depends on sfcr_pkg and sfcr_ram
`timescale 1ns / 1ps

module sfcr_dp #(
   parameter int CHANNEL_COUNT = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sfcr_pkg::cmd_type              cmd,
   output sfcr_pkg::status_type           status,
   input  logic [sfcr_pkg::FuncW-1:0]     req_func,
   input  logic [sfcr_pkg::ChanW-1:0]     req_channel,
   input  logic [sfcr_pkg::ByteW-1:0]     req_write_value,
   input  logic                           csr_valid,
   input  logic [sfcr_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [sfcr_pkg::ByteW-1:0]     csr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sfcr_pkg::ByteW-1:0]     rsp_read_value,
   output logic                           rsp_tx_valid,
   output logic [sfcr_pkg::ByteW-1:0]     rsp_tx_byte,
   output logic                           rsp_frame_start
);

   import sfcr_pkg::*;

   localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   logic [ByteW-1:0]  first_sync_ff;
   logic [ByteW-1:0]  second_sync_ff;
   logic [PhaseW-1:0] phase_ff;
   logic [PhaseW-1:0] phase_in;
   logic [AW-1:0]     send_idx_ff;
   logic [AW-1:0]     send_idx_in;
   logic [AW-1:0]     clr_idx_ff;
   logic [KindW-1:0]  kind_ff;
   logic [KindW-1:0]  kind_in;
   logic              rsp_valid_ff;
   logic [ByteW-1:0]  read_value_ff;
   logic              tx_valid_ff;
   logic [ByteW-1:0]  tx_byte_ff;
   logic              frame_start_ff;

   logic              chan_ok;
   logic              ram_we;
   logic              ram_re;
   logic [AW-1:0]     ram_addr;
   logic [ByteW-1:0]  ram_wdata;
   logic [ByteW-1:0]  ram_rdata;
   logic [ByteW-1:0]  tx_byte_sel;

   assign chan_ok = ({1'b0, req_channel} < (ChanW + 1)'(CHANNEL_COUNT));

   assign status.clear_last  = (clr_idx_ff == AW'(CHANNEL_COUNT - 1));
   assign status.out_blocked = rsp_valid_ff && rsp_stall;

   // decode of the clearing write or the accepted beat, and next frame position
   always_comb begin
      phase_in    = phase_ff;
      send_idx_in = send_idx_ff;
      kind_in     = KIND_NONE;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_addr    = req_channel[AW-1:0];
      ram_wdata   = req_write_value;
      if (cmd.clear_we) begin
         ram_we    = 1'b1;
         ram_addr  = clr_idx_ff;
         ram_wdata = '0;
      end else if (cmd.accept) begin
         unique case (req_func)
            FUNC_WRITE: begin
               ram_we = chan_ok;
            end
            FUNC_READ: begin
               ram_re  = chan_ok;
               kind_in = chan_ok ? KIND_READ : KIND_NONE;
            end
            FUNC_TICK: begin
               unique case (phase_ff)
                  PHASE_SYNC2: begin
                     kind_in     = KIND_SYNC2;
                     send_idx_in = '0;
                     phase_in    = PHASE_DATA;
                  end
                  PHASE_DATA: begin
                     kind_in  = KIND_DATA;
                     ram_re   = 1'b1;
                     ram_addr = send_idx_ff;
                     if (send_idx_ff == AW'(CHANNEL_COUNT - 1)) begin
                        send_idx_in = '0;
                        phase_in    = PHASE_SYNC1;
                     end else begin
                        send_idx_in = send_idx_ff + AW'(1);
                     end
                  end
                  default: begin
                     // unused phase code behaves as first sync
                     kind_in  = KIND_SYNC1;
                     phase_in = PHASE_SYNC2;
                  end
               endcase
            end
            default: begin
               kind_in = KIND_NONE;
            end
         endcase
      end
   end

   sfcr_ram #(
      .WIDTH (ByteW),
      .DEPTH (CHANNEL_COUNT)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      unique case (kind_ff)
         KIND_SYNC1: tx_byte_sel = first_sync_ff;
         KIND_SYNC2: tx_byte_sel = second_sync_ff;
         KIND_DATA:  tx_byte_sel = ram_rdata;
         default:    tx_byte_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= '0;
         second_sync_ff <= '0;
         phase_ff       <= PHASE_SYNC1;
         send_idx_ff    <= '0;
         clr_idx_ff     <= '0;
         kind_ff        <= KIND_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == CSR_FIRST_SYNC)) begin
            first_sync_ff <= csr_data;
         end
         if (csr_valid && (csr_index == CSR_SECOND_SYNC)) begin
            second_sync_ff <= csr_data;
         end
         if (cmd.clear_we) begin
            clr_idx_ff <= clr_idx_ff + AW'(1);
         end
         if (cmd.accept) begin
            kind_ff <= kind_in;
         end
         phase_ff    <= phase_in;
         send_idx_ff <= send_idx_in;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         read_value_ff  <= (kind_ff == KIND_READ) ? ram_rdata : '0;
         tx_valid_ff    <= (kind_ff == KIND_SYNC1) || (kind_ff == KIND_SYNC2)
                           || (kind_ff == KIND_DATA);
         tx_byte_ff     <= tx_byte_sel;
         frame_start_ff <= (kind_ff == KIND_SYNC1);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_tx_valid    = tx_valid_ff;
   assign rsp_tx_byte     = tx_byte_ff;
   assign rsp_frame_start = frame_start_ff;

endmodule

[sv/sync_framed_channel_refresher_core.sv]
// channel refresher top level: controller plus datapath
// depends on sfcr_pkg, sfcr_ctrl, sfcr_dp
//
//  port group | direction | handshake          | carries
//  req_*      | in        | req_valid/req_stall| func, channel, write_value
//  rsp_*      | out       | rsp_valid/rsp_stall| read_value, tx_valid, tx_byte, frame_start
//  csr_*      | in        | csr_valid/csr_ready| index, data (first/second sync byte)
//
// every beat is accepted together with the store access, then loads the result register
// the next beat is taken while the result still waits; a held result delays the load
// after reset the store is cleared one entry a cycle, all CHANNEL_COUNT entries, req_stall high
// csr writes are taken in every cycle, clearing included
`timescale 1ns / 1ps

module sync_framed_channel_refresher_core #(
   parameter int CHANNEL_COUNT = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sfcr_pkg::FuncW-1:0]   req_func,
   input  logic [sfcr_pkg::ChanW-1:0]   req_channel,
   input  logic [sfcr_pkg::ByteW-1:0]   req_write_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sfcr_pkg::ByteW-1:0]   rsp_read_value,
   output logic                         rsp_tx_valid,
   output logic [sfcr_pkg::ByteW-1:0]   rsp_tx_byte,
   output logic                         rsp_frame_start,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sfcr_pkg::CsrIdxW-1:0] csr_index,
   input  logic [sfcr_pkg::ByteW-1:0]   csr_data
);

   import sfcr_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   sfcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfcr_dp #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_channel     (req_channel),
      .req_write_value (req_write_value),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_frame_start (rsp_frame_start)
   );

endmodule

[sv/sfcr_checker.sv]
// port-level checks for the channel refresher, bound to the top level
// depends on sfcr_pkg and the defines header
`timescale 1ns / 1ps
`include "sync_framed_channel_refresher_core_defines.svh"

module sfcr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sfcr_pkg::ByteW-1:0]   rsp_read_value,
   input logic                         rsp_tx_valid,
   input logic                         rsp_frame_start
);

   // store clearing holds off requests right after reset
   `SFCR_ASSERT_NOW(a_clear_after_reset, clock, reset, $past(reset), req_stall)

   // one beat in flight: an accepted beat stalls the next cycle
   `SFCR_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // a held result stays valid
   `SFCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // frame start only on a transmitted byte, and host results carry no byte
   `SFCR_ASSERT_NOW(a_start_has_tx, clock, reset, rsp_valid && rsp_frame_start, rsp_tx_valid)
   `SFCR_ASSERT_NOW(a_tx_excl_read, clock, reset, rsp_valid && rsp_tx_valid, rsp_read_value == '0)

endmodule

bind sync_framed_channel_refresher_core sfcr_checker u_sfcr_checker (.*);
